FILE: rtl/websocket_rx_deframer_assert.svh
// ----------------------------------------------------------------------------
// WebSocket receive deframer assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_RX_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_RX_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define WSRXD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("wsrxd check failed");
`define WSRXD_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("wsrxd check failed");
`else
`define WSRXD_ASSERT(lbl, clk, rst_n, prop)
`define WSRXD_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/wsrxd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket receive deframer package
// Shared types, codes and constants of the deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsrxd_pkg;

  localparam int TIME_BITS   = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_RES     = 3;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT0, PH_EXT1, PH_KEY, PH_PAYLOAD, PH_CLOSED
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_TX    = 2'd1,
    KIND_EVENT = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_PONG_SEEN  = 4'd1,
    EV_PEER_CLOSE = 4'd2,
    EV_UNMASKED   = 4'd3,
    EV_LARGE_CTRL = 4'd4,
    EV_NONMINIMAL = 4'd5,
    EV_HUGE       = 4'd6,
    EV_BAD_OPCODE = 4'd7,
    EV_FLOOD      = 4'd8
  } ev_t;

  localparam logic [9:0] CLOSE_NONE     = 10'd0;
  localparam logic [9:0] CLOSE_PROTOCOL = 10'd1002;
  localparam logic [9:0] CLOSE_POLICY   = 10'd1008;
  localparam logic [9:0] CLOSE_TOO_BIG  = 10'd1009;

  localparam logic [3:0] OP_LAST_DATA  = 4'h2;
  localparam logic [3:0] OP_CONN_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING       = 4'h9;
  localparam logic [3:0] OP_PONG       = 4'hA;

  localparam logic [7:0]  BYTE_CR      = 8'h0D;
  localparam logic [7:0]  BYTE_LF      = 8'h0A;
  localparam logic [7:0]  PONG_HDR     = 8'h8A;
  localparam logic [6:0]  LEN_EXT16    = 7'd126;
  localparam logic [6:0]  LEN_EXT64    = 7'd127;
  localparam logic [15:0] CTRL_MAX_LEN = 16'd125;

  localparam logic [1:0] CFG_NATIVE_PING  = 2'd0;
  localparam logic [1:0] CFG_USER_SOCKET  = 2'd1;
  localparam logic [1:0] CFG_MIN_PING_GAP = 2'd2;

  localparam logic [7:0] MIN_PING_GAP_RST = 8'd10;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    ev_t        ev;
    logic [9:0] code;
  } result_t;

  // One classified input byte: up to three results in order.
  typedef struct packed {
    logic [1:0]                 cnt;
    result_t [MAX_RES-1:0]      res;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } qhead_t;

  function automatic result_t make_res(kind_t kind, logic [7:0] data, ev_t ev,
                                       logic [9:0] code);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.ev   = ev;
    r.code = code;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/wsrxd_front.sv
// ----------------------------------------------------------------------------
// WebSocket receive deframer front end
// Parses frame headers, unmasks payload bytes and turns each byte into a job.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_rx_deframer_assert.svh"

module wsrxd_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire  [1:0]            cfg_index,
  input  wire  [7:0]            cfg_wdata,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [7:0]            in_rx_byte,
  input  wire  [31:0]           in_now_seconds,
  input  wire                   q_full,
  output logic                  push,
  output wsrxd_pkg::job_t       push_job
);

  wsrxd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        final_r, final_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] done_r, done_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  midx_r, midx_nxt;
  logic [wsrxd_pkg::TIME_BITS-1:0] lct_r, lct_nxt;
  logic        native_ping_r, user_socket_r;
  logic [7:0]  gap_r;

  logic        accept;
  logic        is_ctrl;
  logic        flood;
  logic        fin;
  logic        fail;
  wsrxd_pkg::ev_t fail_ev;
  logic [9:0]  fail_code;
  logic [7:0]  plain;
  logic [1:0]  n;
  wsrxd_pkg::job_t job;
  logic [wsrxd_pkg::TIME_BITS-1:0] now_t, gap_t;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_ctrl  = (opcode_r == wsrxd_pkg::OP_PING) || (opcode_r == wsrxd_pkg::OP_PONG);
  assign now_t    = wsrxd_pkg::TIME_BITS'(in_now_seconds);
  assign gap_t    = wsrxd_pkg::TIME_BITS'(gap_r);
  assign flood    = (now_t < gap_t) || ((now_t - gap_t) <= lct_r);
  assign plain    = in_rx_byte ^ key_r[{midx_r, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      native_ping_r <= 1'b1;
      user_socket_r <= 1'b1;
      gap_r         <= wsrxd_pkg::MIN_PING_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wsrxd_pkg::CFG_NATIVE_PING:  native_ping_r <= cfg_wdata[0];
        wsrxd_pkg::CFG_USER_SOCKET:  user_socket_r <= cfg_wdata[0];
        wsrxd_pkg::CFG_MIN_PING_GAP: gap_r         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsrxd_pkg::PH_HDR0;
      opcode_r <= 4'd0;
      final_r  <= 1'b0;
      plen_r   <= 16'd0;
      done_r   <= 16'd0;
      key_r    <= 32'd0;
      midx_r   <= 2'd0;
      lct_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      final_r  <= final_nxt;
      plen_r   <= plen_nxt;
      done_r   <= done_nxt;
      key_r    <= key_nxt;
      midx_r   <= midx_nxt;
      lct_r    <= lct_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    final_nxt  = final_r;
    plen_nxt   = plen_r;
    done_nxt   = done_r;
    key_nxt    = key_r;
    midx_nxt   = midx_r;
    lct_nxt    = lct_r;
    fin        = 1'b0;
    fail       = 1'b0;
    fail_ev    = wsrxd_pkg::EV_NONE;
    fail_code  = wsrxd_pkg::CLOSE_NONE;
    n          = 2'd0;
    job        = '0;

    unique case (phase_r)
      wsrxd_pkg::PH_HDR0: begin
        opcode_nxt = in_rx_byte[3:0];
        final_nxt  = in_rx_byte[7];
        key_nxt    = 32'd0;
        midx_nxt   = 2'd0;
        done_nxt   = 16'd0;
        plen_nxt   = 16'd0;
        if (|in_rx_byte[6:4]) begin
          fail      = 1'b1;
          fail_ev   = wsrxd_pkg::EV_BAD_OPCODE;
          fail_code = wsrxd_pkg::CLOSE_PROTOCOL;
        end else if (in_rx_byte[3:0] <= wsrxd_pkg::OP_LAST_DATA) begin
          phase_nxt = wsrxd_pkg::PH_HDR1;
        end else if (in_rx_byte[3:0] == wsrxd_pkg::OP_CONN_CLOSE) begin
          fail      = 1'b1;
          fail_ev   = wsrxd_pkg::EV_PEER_CLOSE;
        end else if ((in_rx_byte[3:0] == wsrxd_pkg::OP_PING) ||
                     (in_rx_byte[3:0] == wsrxd_pkg::OP_PONG)) begin
          if (flood) begin
            fail      = 1'b1;
            fail_ev   = wsrxd_pkg::EV_FLOOD;
            fail_code = wsrxd_pkg::CLOSE_POLICY;
          end else begin
            lct_nxt   = now_t;
            phase_nxt = wsrxd_pkg::PH_HDR1;
          end
        end else begin
          fail      = 1'b1;
          fail_ev   = wsrxd_pkg::EV_BAD_OPCODE;
          fail_code = wsrxd_pkg::CLOSE_PROTOCOL;
        end
      end
      wsrxd_pkg::PH_HDR1: begin
        if (!in_rx_byte[7]) begin
          fail      = 1'b1;
          fail_ev   = wsrxd_pkg::EV_UNMASKED;
          fail_code = wsrxd_pkg::CLOSE_PROTOCOL;
        end else if (in_rx_byte[6:0] == wsrxd_pkg::LEN_EXT16) begin
          if (is_ctrl) begin
            fail      = 1'b1;
            fail_ev   = wsrxd_pkg::EV_LARGE_CTRL;
            fail_code = wsrxd_pkg::CLOSE_PROTOCOL;
          end else begin
            phase_nxt = wsrxd_pkg::PH_EXT0;
          end
        end else if (in_rx_byte[6:0] == wsrxd_pkg::LEN_EXT64) begin
          fail      = 1'b1;
          fail_ev   = wsrxd_pkg::EV_HUGE;
          fail_code = wsrxd_pkg::CLOSE_TOO_BIG;
        end else begin
          plen_nxt  = {9'd0, in_rx_byte[6:0]};
          phase_nxt = wsrxd_pkg::PH_KEY;
          // A ping is answered by an unmasked pong header of the same length.
          if (opcode_r == wsrxd_pkg::OP_PING) begin
            job.res[0] = wsrxd_pkg::make_res(wsrxd_pkg::KIND_TX, wsrxd_pkg::PONG_HDR,
                                             wsrxd_pkg::EV_NONE, wsrxd_pkg::CLOSE_NONE);
            job.res[1] = wsrxd_pkg::make_res(wsrxd_pkg::KIND_TX, {1'b0, in_rx_byte[6:0]},
                                             wsrxd_pkg::EV_NONE, wsrxd_pkg::CLOSE_NONE);
            n = 2'd2;
          end
        end
      end
      wsrxd_pkg::PH_EXT0: begin
        plen_nxt  = {in_rx_byte, 8'h00};
        phase_nxt = wsrxd_pkg::PH_EXT1;
      end
      wsrxd_pkg::PH_EXT1: begin
        plen_nxt = {plen_r[15:8], in_rx_byte};
        if ({plen_r[15:8], in_rx_byte} <= wsrxd_pkg::CTRL_MAX_LEN) begin
          fail      = 1'b1;
          fail_ev   = wsrxd_pkg::EV_NONMINIMAL;
          fail_code = wsrxd_pkg::CLOSE_PROTOCOL;
        end else begin
          phase_nxt = wsrxd_pkg::PH_KEY;
        end
      end
      wsrxd_pkg::PH_KEY: begin
        key_nxt[{midx_r, 3'b000} +: 8] = key_r[{midx_r, 3'b000} +: 8] | in_rx_byte;
        midx_nxt = midx_r + 2'd1;
        if (midx_r == 2'd3) begin
          done_nxt = 16'd0;
          if (plen_r == 16'd0) begin
            fin = 1'b1;
          end else begin
            phase_nxt = wsrxd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsrxd_pkg::PH_PAYLOAD: begin
        midx_nxt = midx_r + 2'd1;
        if (opcode_r <= wsrxd_pkg::OP_LAST_DATA) begin
          if ((plain != wsrxd_pkg::BYTE_CR) && (plain != wsrxd_pkg::BYTE_LF)) begin
            job.res[n] = wsrxd_pkg::make_res(wsrxd_pkg::KIND_DATA, plain,
                                             wsrxd_pkg::EV_NONE, wsrxd_pkg::CLOSE_NONE);
            n = n + 2'd1;
          end
        end else if (opcode_r == wsrxd_pkg::OP_PING) begin
          job.res[n] = wsrxd_pkg::make_res(wsrxd_pkg::KIND_TX, plain,
                                           wsrxd_pkg::EV_NONE, wsrxd_pkg::CLOSE_NONE);
          n = n + 2'd1;
        end
        done_nxt = done_r + 16'd1;
        if ((done_r + 16'd1) == plen_r) begin
          fin = 1'b1;
        end
      end
      wsrxd_pkg::PH_CLOSED: begin
      end
      default: begin
        phase_nxt = wsrxd_pkg::PH_CLOSED;
      end
    endcase

    // End of frame: a final data frame gets CR LF, a pong may raise its event.
    if (fin) begin
      phase_nxt = wsrxd_pkg::PH_HDR0;
      if (opcode_r <= wsrxd_pkg::OP_LAST_DATA) begin
        if (final_r) begin
          job.res[n] = wsrxd_pkg::make_res(wsrxd_pkg::KIND_DATA, wsrxd_pkg::BYTE_CR,
                                           wsrxd_pkg::EV_NONE, wsrxd_pkg::CLOSE_NONE);
          n = n + 2'd1;
          job.res[n] = wsrxd_pkg::make_res(wsrxd_pkg::KIND_DATA, wsrxd_pkg::BYTE_LF,
                                           wsrxd_pkg::EV_NONE, wsrxd_pkg::CLOSE_NONE);
          n = n + 2'd1;
        end
      end else if (opcode_r == wsrxd_pkg::OP_PONG) begin
        if (user_socket_r && native_ping_r) begin
          job.res[n] = wsrxd_pkg::make_res(wsrxd_pkg::KIND_EVENT, 8'h00,
                                           wsrxd_pkg::EV_PONG_SEEN, wsrxd_pkg::CLOSE_NONE);
          n = n + 2'd1;
        end
      end
    end

    if (fail) begin
      phase_nxt  = wsrxd_pkg::PH_CLOSED;
      job.res[0] = wsrxd_pkg::make_res(wsrxd_pkg::KIND_EVENT, 8'h00, fail_ev, fail_code);
      n          = 2'd1;
    end

    job.cnt = n;
  end

  assign push     = accept && (job.cnt != 2'd0);
  assign push_job = job;

  `WSRXD_NEVER(a_closed_is_silent, clk, rst_n, (phase_r == wsrxd_pkg::PH_CLOSED) && push)
  `WSRXD_ASSERT(a_fail_closes, clk, rst_n, (accept && fail) |=> (phase_r == wsrxd_pkg::PH_CLOSED))

endmodule

`default_nettype wire

FILE: rtl/wsrxd_queue.sv
// ----------------------------------------------------------------------------
// WebSocket receive deframer job queue
// Short FIFO of classified jobs between the front end and the result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_rx_deframer_assert.svh"

module wsrxd_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  wsrxd_pkg::job_t       push_job,
  output logic                  full,
  output wsrxd_pkg::qhead_t     head,
  input  wire                   pop
);

  wsrxd_pkg::job_t entries_r [wsrxd_pkg::QUEUE_DEPTH];
  logic [wsrxd_pkg::QPTR_W-1:0] wptr_r, rptr_r;
  logic [wsrxd_pkg::QCNT_W-1:0] count_r;

  assign full       = (count_r == wsrxd_pkg::QCNT_W'(wsrxd_pkg::QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.job   = entries_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + wsrxd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + wsrxd_pkg::QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + wsrxd_pkg::QCNT_W'(1);
        2'b01:   count_r <= count_r - wsrxd_pkg::QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  `WSRXD_ASSERT(a_count_in_range, clk, rst_n, count_r <= wsrxd_pkg::QCNT_W'(wsrxd_pkg::QUEUE_DEPTH))
  `WSRXD_NEVER(a_pop_when_empty, clk, rst_n, pop && !head.valid)

endmodule

`default_nettype wire

FILE: rtl/wsrxd_back.sv
// ----------------------------------------------------------------------------
// WebSocket receive deframer result stage
// Walks head job results into the output register one per unstalled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_rx_deframer_assert.svh"

module wsrxd_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wsrxd_pkg::qhead_t     head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_byte,
  output logic [3:0]            out_event_res,
  output logic [9:0]            out_close_code,
  output logic                  out_last_of_run
);

  logic                 out_valid_r;
  wsrxd_pkg::result_t   res_r;
  logic                 last_r;
  logic [1:0]           idx_r;
  logic                 load;
  logic                 take;
  logic                 at_last;

  assign load    = !out_valid_r || out_ready;
  assign take    = load && head.valid;
  assign at_last = (idx_r == (head.job.cnt - 2'd1));
  assign pop     = take && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        idx_r       <= at_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r  <= head.job.res[idx_r];
      last_r <= at_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = res_r.kind;
  assign out_byte        = res_r.data;
  assign out_event_res   = res_r.ev;
  assign out_close_code  = res_r.code;
  assign out_last_of_run = last_r;

  `WSRXD_ASSERT(a_job_nonempty, clk, rst_n, head.valid |-> (head.job.cnt != 2'd0))
  `WSRXD_ASSERT(a_idx_in_job, clk, rst_n, head.valid |-> (idx_r < head.job.cnt))

endmodule

`default_nettype wire

FILE: rtl/websocket_rx_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket receive deframer
// Parses client frames byte by byte, unmasks payload, echoes pings and
// reports protocol errors and closes as events.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    in_rx_byte, in_now_seconds
//   out      output     out_valid/out_ready  out_kind, out_byte, out_event_res,
//                                            out_close_code, out_last_of_run
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// One byte is taken per cycle while the four-entry job queue has room.
// The result stage sends one result per cycle while out_ready allows, so a
// byte with two or three results holds the output for each in turn; a taken
// byte's job is written to the queue, then its first result is loaded into
// the output register. Bytes that cause no result never enter the queue.
// Reset (rst_n low, synchronous) restores header parsing and register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module websocket_rx_deframer (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_index,
  input  wire  [7:0]   cfg_wdata,
  input  wire          in_valid,
  output logic         in_ready,
  input  wire  [7:0]   in_rx_byte,
  input  wire  [31:0]  in_now_seconds,
  output logic         out_valid,
  input  wire          out_ready,
  output logic [1:0]   out_kind,
  output logic [7:0]   out_byte,
  output logic [3:0]   out_event_res,
  output logic [9:0]   out_close_code,
  output logic         out_last_of_run
);

  logic               push;
  wsrxd_pkg::job_t    push_job;
  logic               q_full;
  wsrxd_pkg::qhead_t  head;
  logic               pop;

  wsrxd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .in_now_seconds (in_now_seconds),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  wsrxd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .head     (head),
    .pop      (pop)
  );

  wsrxd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_event_res   (out_event_res),
    .out_close_code  (out_close_code),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

FILE: bench/websocket_rx_deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket receive deframer checker
// Watches the byte, result and register ports of the deframer, predicts the
// results of every accepted byte and compares each accepted result with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------

module websocket_rx_deframer_checker
  import wsrxd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic [31:0] in_now_seconds,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_byte,
  input  logic [3:0]  out_event_res,
  input  logic [9:0]  out_close_code,
  input  logic        out_last_of_run,
  output int          n_pending,
  output int          n_fail
);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    ev_t        ev;
    logic [9:0] code;
    logic       last;
  } deframed_t;

  logic       native_ping_q;
  logic       user_socket_q;
  logic [7:0] ping_gap_q;

  phase_t      ph;
  logic [3:0]  opc;
  logic        fin;
  logic [15:0] plen;
  logic [15:0] done_cnt;
  logic [31:0] key;
  logic [1:0]  kidx;
  logic [31:0] last_ctl;

  deframed_t burst[$];
  deframed_t pending_results[$];
  deframed_t want;
  int        mismatches = 0;

  task automatic add_res(input kind_t kind, input logic [7:0] data, input ev_t ev,
                         input logic [9:0] code);
    deframed_t r;
    r = '{kind, data, ev, code, 1'b0};
    burst.insert(burst.size(), r);
  endtask

  task automatic close_link(input ev_t ev, input logic [9:0] code);
    add_res(KIND_EVENT, 8'h00, ev, code);
    ph = PH_CLOSED;
  endtask

  task automatic frame_done();
    if (opc <= OP_LAST_DATA) begin
      if (fin) begin
        add_res(KIND_DATA, BYTE_CR, EV_NONE, CLOSE_NONE);
        add_res(KIND_DATA, BYTE_LF, EV_NONE, CLOSE_NONE);
      end
    end else if (opc == OP_PONG && user_socket_q && native_ping_q) begin
      add_res(KIND_EVENT, 8'h00, EV_PONG_SEEN, CLOSE_NONE);
    end
    ph = PH_HDR0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic [31:0] now);
    logic [7:0] plain;
    logic       ctl;
    deframed_t  r;
    burst.delete();
    ctl = (opc == OP_PING) || (opc == OP_PONG);
    case (ph)
      PH_HDR0: begin
        opc      = b[3:0];
        fin      = b[7];
        key      = '0;
        kidx     = '0;
        done_cnt = '0;
        plen     = '0;
        if (b[6:4] != 3'b000) begin
          close_link(EV_BAD_OPCODE, CLOSE_PROTOCOL);
        end else if (opc <= OP_LAST_DATA) begin
          ph = PH_HDR1;
        end else if (opc == OP_CONN_CLOSE) begin
          close_link(EV_PEER_CLOSE, CLOSE_NONE);
        end else if (opc == OP_PING || opc == OP_PONG) begin
          // A control frame must arrive strictly later than last time plus the gap.
          if ({1'b0, now} <= {1'b0, last_ctl} + {25'd0, ping_gap_q}) begin
            close_link(EV_FLOOD, CLOSE_POLICY);
          end else begin
            last_ctl = now;
            ph = PH_HDR1;
          end
        end else begin
          close_link(EV_BAD_OPCODE, CLOSE_PROTOCOL);
        end
      end
      PH_HDR1: begin
        if (!b[7]) begin
          close_link(EV_UNMASKED, CLOSE_PROTOCOL);
        end else if (b[6:0] == LEN_EXT16) begin
          if (ctl) close_link(EV_LARGE_CTRL, CLOSE_PROTOCOL);
          else ph = PH_EXT0;
        end else if (b[6:0] == LEN_EXT64) begin
          close_link(EV_HUGE, CLOSE_TOO_BIG);
        end else begin
          plen = {9'd0, b[6:0]};
          ph = PH_KEY;
          if (opc == OP_PING) begin
            add_res(KIND_TX, PONG_HDR, EV_NONE, CLOSE_NONE);
            add_res(KIND_TX, {1'b0, b[6:0]}, EV_NONE, CLOSE_NONE);
          end
        end
      end
      PH_EXT0: begin
        plen = {b, 8'h00};
        ph = PH_EXT1;
      end
      PH_EXT1: begin
        plen = {plen[15:8], b};
        if (plen <= CTRL_MAX_LEN) close_link(EV_NONMINIMAL, CLOSE_PROTOCOL);
        else ph = PH_KEY;
      end
      PH_KEY: begin
        key  = key | ({24'd0, b} << (8 * kidx));
        kidx = kidx + 2'd1;
        if (kidx == 2'd0) begin
          done_cnt = '0;
          if (plen == 16'd0) frame_done();
          else ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        plain = b ^ key[8*kidx +: 8];
        kidx  = kidx + 2'd1;
        if (opc <= OP_LAST_DATA) begin
          if (plain != BYTE_CR && plain != BYTE_LF)
            add_res(KIND_DATA, plain, EV_NONE, CLOSE_NONE);
        end else if (opc == OP_PING) begin
          add_res(KIND_TX, plain, EV_NONE, CLOSE_NONE);
        end
        done_cnt = done_cnt + 16'd1;
        if (done_cnt == plen) frame_done();
      end
      default: ph = PH_CLOSED;
    endcase
    if (burst.size() > 0) begin
      r = burst[burst.size() - 1];
      r.last = 1'b1;
      burst[burst.size() - 1] = r;
      foreach (burst[i]) pending_results.insert(pending_results.size(), burst[i]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      native_ping_q = 1'b1;
      user_socket_q = 1'b1;
      ping_gap_q    = MIN_PING_GAP_RST;
      ph            = PH_HDR0;
      opc           = '0;
      fin           = 1'b0;
      plen          = '0;
      done_cnt      = '0;
      key           = '0;
      kidx          = '0;
      last_ctl      = '0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: kind %0d byte %02h event %0d code %0d",
                   $time, out_kind, out_byte, out_event_res, out_close_code);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_kind !== want.kind) begin
            $display("%0t: kind expected %0d, actual %0d", $time, want.kind, out_kind);
            mismatches++;
          end
          if (out_byte !== want.data) begin
            $display("%0t: byte expected %02h, actual %02h", $time, want.data, out_byte);
            mismatches++;
          end
          if (out_event_res !== want.ev) begin
            $display("%0t: event expected %0d, actual %0d", $time, want.ev, out_event_res);
            mismatches++;
          end
          if (out_close_code !== want.code) begin
            $display("%0t: close code expected %0d, actual %0d",
                     $time, want.code, out_close_code);
            mismatches++;
          end
          if (out_last_of_run !== want.last) begin
            $display("%0t: last flag expected %0b, actual %0b",
                     $time, want.last, out_last_of_run);
            mismatches++;
          end
        end
      end
      // A byte taken at the same edge as a register write still sees the old value.
      if (in_valid && in_ready) deframe_byte(in_rx_byte, in_now_seconds);
      if (cfg_we) begin
        case (cfg_index)
          CFG_NATIVE_PING:  native_ping_q = cfg_wdata[0];
          CFG_USER_SOCKET:  user_socket_q = cfg_wdata[0];
          CFG_MIN_PING_GAP: ping_gap_q    = cfg_wdata;
          default: ;
        endcase
      end
    end
    n_pending <= pending_results.size();
    n_fail    <= mismatches;
  end

endmodule

FILE: bench/tb_websocket_rx_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket receive deframer testbench
// Sends directed and random client frames (data, ping, pong) under three
// register settings and three idle patterns, then ends on one randomly chosen
// error or close followed by bytes that must be dropped. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_websocket_rx_deframer;
  import wsrxd_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [3:0] OP_CONT    = 4'h0;
  localparam logic [3:0] OP_TEXT    = 4'h1;
  localparam logic [3:0] OP_BIN     = OP_LAST_DATA;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic [31:0] in_now_seconds;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [3:0]  out_event_res;
  logic [9:0]  out_close_code;
  logic        out_last_of_run;

  int          n_pending;
  int          n_fail;
  int          send_idle  = 16;
  int          recv_idle  = 78;
  int          items_sent = 0;
  int          goal;
  logic [7:0]  ping_gap   = MIN_PING_GAP_RST;
  logic [31:0] ctl_time   = '0;

  websocket_rx_deframer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .in_now_seconds  (in_now_seconds),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_event_res   (out_event_res),
    .out_close_code  (out_close_code),
    .out_last_of_run (out_last_of_run)
  );

  websocket_rx_deframer_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .in_now_seconds  (in_now_seconds),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_event_res   (out_event_res),
    .out_close_code  (out_close_code),
    .out_last_of_run (out_last_of_run),
    .n_pending       (n_pending),
    .n_fail          (n_fail)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // The ready flag only changes at clock edges, so it is looked at mid-cycle
  // to learn whether the coming edge takes the item.
  task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_now_seconds <= t;
    items_sent++;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Control frames carry a time just past the flood window plus some slack.
  task automatic send_frame(input logic fin, input logic [3:0] opc,
                            input logic [15:0] len, input int slack);
    logic [31:0] mask;
    logic [7:0]  plain;
    int          i;
    mask = $urandom;
    if (opc == OP_PING || opc == OP_PONG) begin
      ctl_time = ctl_time + ping_gap + 32'd1 + slack;
      send_byte({fin, 3'b000, opc}, ctl_time);
    end else begin
      send_byte({fin, 3'b000, opc}, rand_time());
    end
    if (len > CTRL_MAX_LEN) begin
      send_byte({1'b1, LEN_EXT16}, rand_time());
      send_byte(len[15:8], rand_time());
      send_byte(len[7:0], rand_time());
    end else begin
      send_byte({1'b1, len[6:0]}, rand_time());
    end
    for (i = 0; i < 4; i++) send_byte(mask[8*i +: 8], rand_time());
    for (i = 0; i < int'(len); i++) begin
      case ($urandom_range(0, 7))
        0:       plain = BYTE_CR;
        1:       plain = BYTE_LF;
        default: plain = 8'($urandom);
      endcase
      send_byte(plain ^ mask[8*(i%4) +: 8], rand_time());
    end
  endtask

  task automatic random_frame();
    int          pick;
    logic [15:0] len;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      if ($urandom_range(0, 11) == 0) len = 16'($urandom_range(126, 200));
      else if ($urandom_range(0, 15) == 0) len = CTRL_MAX_LEN;
      else len = 16'($urandom_range(0, 12));
      send_frame(1'($urandom), 4'($urandom_range(0, 2)), len, $urandom_range(0, 3));
    end else begin
      len = ($urandom_range(0, 15) == 0) ? CTRL_MAX_LEN : 16'($urandom_range(0, 8));
      send_frame(1'($urandom), (pick < 8) ? OP_PING : OP_PONG, len, $urandom_range(0, 3));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // The one-bit registers get random upper bits, which the block must ignore.
  task automatic set_config(input logic native, input logic user, input logic [7:0] gap);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NATIVE_PING;
    cfg_wdata <= {7'($urandom), native};
    @(posedge clk);
    cfg_index <= CFG_USER_SOCKET;
    cfg_wdata <= {7'($urandom), user};
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_index <= CFG_MIN_PING_GAP;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_we   <= 1'b0;
    ping_gap = gap;
  endtask

  // Ends the connection one way or another; later bytes must give nothing.
  task automatic send_closing_run();
    logic [3:0] opc;
    int         i;
    case ($urandom_range(0, 7))
      0: send_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)}, rand_time());
      1: begin
        send_byte({1'b1, 3'b000, 4'($urandom_range(0, 2))}, rand_time());
        send_byte({1'b0, 7'($urandom)}, rand_time());
      end
      2: begin
        ctl_time = ctl_time + ping_gap + 32'd1;
        send_byte({1'b1, 3'b000, ($urandom_range(0, 1) ? OP_PING : OP_PONG)}, ctl_time);
        send_byte({1'b1, LEN_EXT16}, rand_time());
      end
      3: begin
        send_byte({1'b1, 3'b000, 4'($urandom_range(0, 2))}, rand_time());
        send_byte({1'b1, LEN_EXT16}, rand_time());
        send_byte(8'h00, rand_time());
        send_byte(8'($urandom_range(0, 125)), rand_time());
      end
      4: begin
        send_byte({1'b1, 3'b000, 4'($urandom_range(0, 2))}, rand_time());
        send_byte({1'b1, LEN_EXT64}, rand_time());
      end
      5: begin
        do opc = 4'($urandom);
        while (opc <= OP_LAST_DATA || opc == OP_CONN_CLOSE || opc == OP_PING ||
               opc == OP_PONG);
        send_byte({1'($urandom), 3'b000, opc}, rand_time());
      end
      6: send_byte({1'($urandom), 3'b000, ($urandom_range(0, 1) ? OP_PING : OP_PONG)},
                   ctl_time + $urandom_range(0, ping_gap));
      default: send_byte({1'($urandom), 3'b000, OP_CONN_CLOSE}, rand_time());
    endcase
    for (i = 0; i < 6; i++) send_byte(8'($urandom), rand_time());
  endtask

  initial begin
    #(2_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_NATIVE_PING;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_rx_byte     <= '0;
    in_now_seconds <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items run with the register values from reset.
    send_frame(1'b1, OP_TEXT, 16'd0, 0);
    // An all-ones key turns 00/FF into FF/00 and the inverted CR and LF into
    // CR and LF, which are dropped before the appended pair.
    send_byte({1'b1, 3'b000, OP_BIN}, 32'h0000_0000);
    send_byte({1'b1, 7'd4}, 32'hFFFF_FFFF);
    repeat (4) send_byte(8'hFF, 32'h0000_0000);
    send_byte(8'h00, 32'hFFFF_FFFF);
    send_byte(8'hFF, 32'h0000_0000);
    send_byte(~BYTE_CR, 32'hFFFF_FFFF);
    send_byte(~BYTE_LF, 32'h0000_0000);
    send_frame(1'b1, OP_PING, 16'd0, 0);
    send_frame(1'b0, OP_PONG, 16'd1, 0);

    set_config(1'b0, 1'b1, 8'd0);
    goal = items_sent + 40;
    while (items_sent < goal) random_frame();

    send_idle = 78;
    recv_idle = 16;
    set_config(1'b1, 1'b0, 8'hFF);
    goal = items_sent + 40;
    while (items_sent < goal) random_frame();

    send_idle = 0;
    recv_idle = 0;
    set_config(1'b1, 1'b1, 8'($urandom_range(1, 254)));
    goal = items_sent + 40;
    while (items_sent < goal) random_frame();
    send_frame(1'b1, OP_CONT, 16'd3, 0);
    send_closing_run();

    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: websocket_rx_deframer.f
+incdir+rtl
rtl/wsrxd_pkg.sv
rtl/wsrxd_front.sv
rtl/wsrxd_queue.sv
rtl/wsrxd_back.sv
rtl/websocket_rx_deframer.sv
bench/websocket_rx_deframer_checker.sv
bench/tb_websocket_rx_deframer.sv
